FILE: rtl/core/gast_pkg.sv
// shared types, constants and control structs of the generational slot table
package gast_pkg;

   localparam int SLOT_INDEX_BITS = 12;
   localparam int SLOT_COUNT      = 1 << SLOT_INDEX_BITS;
   localparam int WORD_BITS       = 64;
   localparam int GEN_BITS        = WORD_BITS - SLOT_INDEX_BITS - 1;
   localparam int OP_BITS         = 4;
   localparam int STATUS_BITS     = 2;

   typedef logic [SLOT_INDEX_BITS-1:0] slot_type;
   typedef logic [GEN_BITS-1:0]        gen_type;
   typedef logic [WORD_BITS-1:0]       word_type;

   localparam gen_type GEN_LIMIT = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_ALLOC = 4'd0,
      OP_LOAD  = 4'd1,
      OP_STORE = 4'd2,
      OP_SWAP  = 4'd3,
      OP_CAS   = 4'd4,
      OP_ADD   = 4'd5,
      OP_SUB   = 4'd6,
      OP_AND   = 4'd7,
      OP_OR    = 4'd8,
      OP_XOR   = 4'd9,
      OP_FREE  = 4'd10
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE   = 2'd0,
      ST_REJECT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic    open;
      gen_type gen;
   } meta_type;

   localparam int META_BITS = $bits(meta_type);

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic exec_done;
      logic scan_next;
      logic alloc_done;
      logic full_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_valid;
      logic req_alloc;
      logic out_free;
      logic slot_free;
      logic scan_last;
   } ctrl_status_type;

endpackage

FILE: rtl/core/gast_req_if.sv
// request channel: valid, ready and the request word
interface gast_req_if;
   import gast_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          op;
   logic signed [WORD_BITS-1:0] handle;
   logic signed [WORD_BITS-1:0] operand;
   logic signed [WORD_BITS-1:0] expected;

   modport source (output valid, output op, output handle, output operand,
                   output expected, input ready);
   modport sink   (input valid, input op, input handle, input operand,
                   input expected, output ready);
endinterface

FILE: rtl/core/gast_rsp_if.sv
// response channel: valid, ready and the response word
interface gast_rsp_if;
   import gast_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] result;
   logic [STATUS_BITS-1:0]      status;

   modport source (output valid, output result, output status, input ready);
   modport sink   (input valid, input result, input status, output ready);
endinterface

FILE: rtl/core/generational_atomic_slot_table_core.sv
// top level of the generational slot table: controller and datapath
// usage:
//  requests enter on req_chan (valid/ready); a word is taken when both are high.
//  each request gives exactly one response word on rsp_chan, in request order.
//  handles are {0, generation, slot index}; a nonpositive or stale handle is
//  answered with result 0 and status rejected, a full table with status full.
//  for an access op the slot memories are read in the accept cycle and written
//  back when the op finishes, once the response register is free.
//  allocate reads one slot a cycle from the rotating hint, 1 to 4096 slots
//  in all, until it finds a free slot or reaches the last one.
//  one request is in work at a time; a new one is taken once the previous has
//  reached the response register, even while that word still waits.
//  a stalled receiver holds the response register; a finished request then
//  waits in its last step until the register frees.
//  after reset the slot metadata memory is cleared in one pass over all 4096
//  slots, one slot a cycle, during which req_chan.ready stays low.
module generational_atomic_slot_table_core (
   input logic        clock,
   input logic        reset,
   gast_req_if.sink   req_chan,
   gast_rsp_if.source rsp_chan
);
   import gast_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;

   gast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   gast_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );
endmodule

FILE: rtl/core/gast_ram.sv
// generic ram with one write port and one registered read port
module gast_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/gast_ctrl.sv
// controller state machine: clearing pass, accept, execute and allocation scan
module gast_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  gast_pkg::ctrl_status_type status,
   output gast_pkg::ctrl_cmd_type    cmd,
   output logic                      req_ready
);
   import gast_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_SCAN  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_alloc ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.exec_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            priority if (status.slot_free) begin
               if (status.out_free) begin
                  cmd.alloc_done = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (status.scan_last) begin
               if (status.out_free) begin
                  cmd.full_done = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end
endmodule

FILE: rtl/core/gast_datapath.sv
// datapath: request registers, slot memories, handle check, alu and response register
module gast_datapath (
   input  logic                      clock,
   input  logic                      reset,
   gast_req_if.sink                  req,
   gast_rsp_if.source                rsp,
   input  logic                      req_ready,
   input  gast_pkg::ctrl_cmd_type    cmd,
   output gast_pkg::ctrl_status_type status
);
   import gast_pkg::*;

   logic [OP_BITS-1:0] op_ff;
   word_type           handle_ff;
   word_type           operand_ff;
   word_type           expected_ff;
   slot_type           hint_ff;
   slot_type           hint_in;
   slot_type           scan_addr_ff;
   slot_type           scan_addr_in;
   slot_type           step_ff;
   slot_type           step_in;
   slot_type           clear_addr_ff;
   slot_type           clear_addr_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   word_type           rsp_result_ff;
   word_type           rsp_result_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;

   logic               meta_we;
   slot_type           meta_waddr;
   meta_type           meta_wdata;
   logic               meta_re;
   slot_type           meta_raddr;
   logic [META_BITS-1:0] meta_rdata;
   meta_type           meta_rd;
   logic               value_we;
   slot_type           value_waddr;
   word_type           value_wdata;
   slot_type           value_raddr;
   word_type           old_value;

   slot_type           req_slot;
   slot_type           exec_slot;
   gen_type            exec_gen;
   logic               handle_ok;
   logic               op_valid;
   logic               cas_match;
   logic               exec_value_we;
   word_type           exec_value;
   word_type           exec_result;
   gen_type            next_gen;
   logic               out_free;

   assign req.ready  = req_ready;
   assign req_slot   = req.handle[SLOT_INDEX_BITS-1:0];
   assign exec_slot  = handle_ff[SLOT_INDEX_BITS-1:0];
   assign exec_gen   = handle_ff[WORD_BITS-2:SLOT_INDEX_BITS];
   assign meta_rd    = meta_type'(meta_rdata);
   assign next_gen   = gen_type'(meta_rd.gen + 1'b1);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   assign op_valid   = op_ff <= OP_FREE;
   assign handle_ok  = op_valid && !handle_ff[WORD_BITS-1] && (exec_gen != '0)
                       && (meta_rd.gen == exec_gen) && meta_rd.open;
   assign cas_match  = old_value == expected_ff;

   gast_ram #(
      .WIDTH (META_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   gast_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (value_waddr),
      .wr_data (value_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (value_raddr),
      .rd_data (old_value)
   );

   // read addresses
   always_comb begin
      meta_re     = cmd.accept || cmd.scan_next;
      value_raddr = req_slot;
      if (cmd.accept) begin
         meta_raddr = (req.op == OP_ALLOC) ? hint_ff : req_slot;
      end else begin
         meta_raddr = scan_addr_in;
      end
   end

   // cell alu
   always_comb begin
      exec_value    = operand_ff;
      exec_value_we = 1'b0;
      exec_result   = old_value;
      unique case (op_ff)
         OP_LOAD: begin
         end
         OP_STORE: begin
            exec_value_we = 1'b1;
            exec_result   = '0;
         end
         OP_SWAP: begin
            exec_value_we = 1'b1;
         end
         OP_CAS: begin
            exec_value_we = cas_match;
            exec_result   = cas_match ? word_type'(1) : '0;
         end
         OP_ADD: begin
            exec_value_we = 1'b1;
            exec_value    = old_value + operand_ff;
         end
         OP_SUB: begin
            exec_value_we = 1'b1;
            exec_value    = old_value - operand_ff;
         end
         OP_AND: begin
            exec_value_we = 1'b1;
            exec_value    = old_value & operand_ff;
         end
         OP_OR: begin
            exec_value_we = 1'b1;
            exec_value    = old_value | operand_ff;
         end
         OP_XOR: begin
            exec_value_we = 1'b1;
            exec_value    = old_value ^ operand_ff;
         end
         default: begin
            exec_result = '0;
         end
      endcase
   end

   // memory writes
   always_comb begin
      meta_we     = 1'b0;
      meta_waddr  = exec_slot;
      meta_wdata  = '{open: 1'b0, gen: meta_rd.gen};
      value_we    = 1'b0;
      value_waddr = exec_slot;
      value_wdata = exec_value;
      priority if (cmd.clear_en) begin
         meta_we    = 1'b1;
         meta_waddr = clear_addr_ff;
         meta_wdata = '0;
      end else if (cmd.exec_done) begin
         meta_we  = handle_ok && (op_ff == OP_FREE);
         value_we = handle_ok && exec_value_we;
      end else if (cmd.alloc_done) begin
         meta_we     = 1'b1;
         meta_waddr  = scan_addr_ff;
         meta_wdata  = '{open: 1'b1, gen: next_gen};
         value_we    = 1'b1;
         value_waddr = scan_addr_ff;
         value_wdata = operand_ff;
      end else begin
      end
   end

   // scan, hint and clear counters
   always_comb begin
      hint_in       = hint_ff;
      scan_addr_in  = scan_addr_ff;
      step_in       = step_ff;
      clear_addr_in = clear_addr_ff;
      if (cmd.clear_en) begin
         clear_addr_in = slot_type'(clear_addr_ff + 1'b1);
      end
      if (cmd.accept && (req.op == OP_ALLOC)) begin
         hint_in      = slot_type'(hint_ff + 1'b1);
         scan_addr_in = hint_ff;
         step_in      = '0;
      end
      if (cmd.scan_next) begin
         scan_addr_in = slot_type'(scan_addr_ff + 1'b1);
         step_in      = slot_type'(step_ff + 1'b1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      priority if (cmd.exec_done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = handle_ok ? exec_result : '0;
         rsp_status_in = handle_ok ? ST_DONE : ST_REJECT;
      end else if (cmd.alloc_done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = {1'b0, next_gen, scan_addr_ff};
         rsp_status_in = ST_DONE;
      end else if (cmd.full_done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = '0;
         rsp_status_in = ST_FULL;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff       <= '0;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hint_ff       <= hint_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req.op;
         handle_ff   <= req.handle;
         operand_ff  <= req.operand;
         expected_ff <= req.expected;
      end
      scan_addr_ff  <= scan_addr_in;
      step_ff       <= step_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.result = rsp_result_ff;
   assign rsp.status = rsp_status_ff;

   assign status.clear_last = clear_addr_ff == '1;
   assign status.req_valid  = req.valid;
   assign status.req_alloc  = req.op == OP_ALLOC;
   assign status.out_free   = out_free;
   assign status.slot_free  = !meta_rd.open && (meta_rd.gen != GEN_LIMIT);
   assign status.scan_last  = step_ff == '1;
endmodule
